// ===== rtl/cop_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cop_pkg
// Shared constants and types for the circle octant pixel addresser.
// ----------------------------------------------------------------------------
package cop_pkg;
   localparam int CoordW   = 10;
   localparam int DimW     = 11;
   localparam int AddrW    = 22;
   localparam int NumOct   = 8;
   localparam int DistW    = 21;
   localparam int RootW    = 11;
   localparam int DefMaxW  = 1024;
   localparam int DefMaxH  = 1024;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;
   localparam int ReqDataW = 16;
   localparam int RspDataW = 184;

   typedef enum logic [CsrIdxW-1:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_RIM_X    = 3'd2,
      REG_RIM_Y    = 3'd3,
      REG_WIDTH    = 3'd4,
      REG_HEIGHT   = 3'd5
   } reg_idx_type;
endpackage
`default_nettype wire

// ===== rtl/circle_octant_pixel_addresser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_octant_pixel_addresser_top
// Eight-way symmetric circle column addresser, pipelined integer square root.
// ----------------------------------------------------------------------------
// channel | dir | content
// req_    | in  | column_offset
// rsp_    | out | eight octant addresses, valid_mask, column_active
// csr_    | in  | register index and data
// One column per clock while rsp_ is not stalled; 11 root stages, one per
// result bit, plus setup, rounding and address stages.
// Synchronous reset clears valid bits and restores the register defaults.
// A stall on rsp_ freezes the whole pipe; nothing is lost or repeated.
module circle_octant_pixel_addresser_top #(
   parameter int MAX_WIDTH  = cop_pkg::DefMaxW,
   parameter int MAX_HEIGHT = cop_pkg::DefMaxH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [cop_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [cop_pkg::CsrDataW-1:0] csr_data,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [cop_pkg::ReqDataW-1:0] req_tdata,  // column_offset[9:0]
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // addr_oct0..7 (22 bits each, from bit 0), valid_mask[183:176]
   output logic [cop_pkg::RspDataW-1:0]      rsp_tdata,
   output logic                              rsp_tuser   // column_active
);
   import cop_pkg::*;

   localparam int NS = RootW;          // root stages
   localparam int AW = 40;             // wide signed address math
   localparam int RW = 16;             // signed row and width operands
   localparam int MWW = $clog2(MAX_WIDTH + 1);
   localparam int MHW = $clog2(MAX_HEIGHT + 1);

   logic [CoordW-1:0] cx_ff, cy_ff, rx_ff, ry_ff;
   logic [DimW-1:0]   iw_ff, ih_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0; cy_ff <= '0; rx_ff <= '0; ry_ff <= '0;
         iw_ff <= DimW'(1024); ih_ff <= DimW'(1024);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CENTER_X: cx_ff <= csr_data[CoordW-1:0];
            REG_CENTER_Y: cy_ff <= csr_data[CoordW-1:0];
            REG_RIM_X:    rx_ff <= csr_data[CoordW-1:0];
            REG_RIM_Y:    ry_ff <= csr_data[CoordW-1:0];
            REG_WIDTH:    iw_ff <= csr_data[DimW-1:0];
            REG_HEIGHT:   ih_ff <= csr_data[DimW-1:0];
            default: ;
         endcase
      end
   end

   // Clamped dimensions (static between items).
   logic [MWW-1:0] w_c;
   logic [MHW-1:0] h_c;
   always_comb begin
      if (32'(iw_ff) > 32'(MAX_WIDTH)) w_c = MWW'(MAX_WIDTH);
      else                             w_c = MWW'(iw_ff);
      if (32'(ih_ff) > 32'(MAX_HEIGHT)) h_c = MHW'(MAX_HEIGHT);
      else                              h_c = MHW'(ih_ff);
   end

   wire adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Stage 0: squared distance and x^2.
   logic              v0_ff;
   logic [CoordW-1:0] x0_ff;
   logic [DistW-1:0]  d0_ff;
   logic [DistW-1:0]  xx0_ff;
   logic [CoordW-1:0] adx, ady;
   always_comb begin
      adx = (cx_ff >= rx_ff) ? cx_ff - rx_ff : rx_ff - cx_ff;
      ady = (cy_ff >= ry_ff) ? cy_ff - ry_ff : ry_ff - cy_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= req_tvalid;
      if (adv) begin
         x0_ff  <= req_tdata[CoordW-1:0];
         d0_ff  <= DistW'(adx) * DistW'(adx) + DistW'(ady) * DistW'(ady);
         xx0_ff <= DistW'(req_tdata[CoordW-1:0]) * DistW'(req_tdata[CoordW-1:0]);
      end
   end

   // Root pipe state; entry 0 is the stage 1 register.
   logic              vr_ff  [NS+1];
   logic              ar_ff  [NS+1];
   logic [CoordW-1:0] xr_ff  [NS+1];
   logic [DistW-1:0]  er_ff  [NS+1];
   logic [DistW+1:0]  rem_ff [NS+1];
   logic [RootW-1:0]  rt_ff  [NS+1];

   // Stage 1: active test, E.
   wire [DistW+1:0] lhs = {xx0_ff, 2'b00} + {11'd0, x0_ff, 2'b00} + 23'd1;
   always_ff @(posedge clock) begin
      if (reset) vr_ff[0] <= 1'b0;
      else if (adv) vr_ff[0] <= v0_ff;
      if (adv) begin
         xr_ff[0]  <= x0_ff;
         ar_ff[0]  <= lhs <= {1'b0, d0_ff, 1'b0};
         er_ff[0]  <= d0_ff - xx0_ff;
         rem_ff[0] <= '0;
         rt_ff[0]  <= '0;
      end
   end

   // Root stages: restoring, one result bit per stage.
   for (genvar s = 0; s < NS; s++) begin : g_root
      localparam int B = NS - 1 - s;
      logic [DistW+1:0] rin, trial;
      logic [DistW-1:0] es;
      always_comb begin
         es    = er_ff[s] >> (2 * B);
         rin   = {rem_ff[s][DistW-1:0], es[1:0]};
         trial = {(DistW+2-RootW-2)'(0), rt_ff[s], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (reset) vr_ff[s+1] <= 1'b0;
         else if (adv) vr_ff[s+1] <= vr_ff[s];
         if (adv) begin
            ar_ff[s+1] <= ar_ff[s];
            xr_ff[s+1] <= xr_ff[s];
            er_ff[s+1] <= er_ff[s];
            if (rin >= trial) begin
               rem_ff[s+1] <= rin - trial;
               rt_ff[s+1]  <= {rt_ff[s][RootW-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= rin;
               rt_ff[s+1]  <= {rt_ff[s][RootW-2:0], 1'b0};
            end
         end
      end
   end

   // Rounding: E - k^2 = rem; round up when rem > k.
   logic              vy_ff, ay_ff, sk_ff;
   logic [CoordW-1:0] xy_ff;
   logic [RootW:0]    y_ff;
   wire [RootW:0] ynext = {1'b0, rt_ff[NS]} +
                          (RootW+1)'(rem_ff[NS] > (DistW+2)'(rt_ff[NS]));
   always_ff @(posedge clock) begin
      if (reset) vy_ff <= 1'b0;
      else if (adv) vy_ff <= vr_ff[NS];
      if (adv) begin
         ay_ff <= ar_ff[NS];
         xy_ff <= xr_ff[NS];
         y_ff  <= ynext;
         sk_ff <= !ar_ff[NS] || (32'(xr_ff[NS]) > 32'(w_c)) || (32'(ynext) > 32'(h_c));
      end
   end

   // Row bases 4*W*row for the four distinct rows, column bases 4*col.
   logic              vb_ff, ab_ff, sb_ff;
   logic signed [AW-1:0] rb_ff [4];   // cy+y, cy+x, cy-y, cy-x
   logic signed [AW-1:0] cb_ff [4];   // cx+x, cx+y, cx-y, cx-x
   logic signed [RW-1:0] rr [4];
   logic signed [RW-1:0] sw;
   logic signed [2*RW-1:0] rp [4];
   always_comb begin
      sw = RW'(w_c);
      rr[0] = RW'(cy_ff) + RW'(y_ff);
      rr[1] = RW'(cy_ff) + RW'(xy_ff);
      rr[2] = RW'(cy_ff) - RW'(y_ff);
      rr[3] = RW'(cy_ff) - RW'(xy_ff);
      for (int i = 0; i < 4; i++) rp[i] = rr[i] * sw;
   end
   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else if (adv) vb_ff <= vy_ff;
      if (adv) begin
         ab_ff <= ay_ff;
         sb_ff <= sk_ff;
         for (int i = 0; i < 4; i++) rb_ff[i] <= AW'(rp[i]) <<< 2;
         cb_ff[0] <= (AW'(cx_ff) + AW'(xy_ff)) <<< 2;
         cb_ff[1] <= (AW'(cx_ff) + AW'(y_ff)) <<< 2;
         cb_ff[2] <= (AW'(cx_ff) - AW'(y_ff)) <<< 2;
         cb_ff[3] <= (AW'(cx_ff) - AW'(xy_ff)) <<< 2;
      end
   end

   // Final: sum, range check, output register.
   logic signed [AW-1:0] a [NumOct];
   logic signed [AW-1:0] lim;
   logic [31:0]          area;
   always_comb begin
      area = 32'(w_c) * 32'(h_c);
      lim  = AW'(area) <<< 2;
      a[0] = rb_ff[0] + cb_ff[0];
      a[1] = rb_ff[1] + cb_ff[1];
      a[2] = rb_ff[1] + cb_ff[2];
      a[3] = rb_ff[2] + cb_ff[0];
      a[4] = rb_ff[2] + cb_ff[3];
      a[5] = rb_ff[3] + cb_ff[2];
      a[6] = rb_ff[3] + cb_ff[1];
      a[7] = rb_ff[0] + cb_ff[3];
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid <= 1'b0;
      else if (adv) rsp_tvalid <= vb_ff;
      if (adv) begin
         rsp_tuser <= ab_ff;
         for (int i = 0; i < NumOct; i++) begin
            if (!sb_ff && a[i] >= 0 && a[i] < lim) begin
               rsp_tdata[i*AddrW +: AddrW] <= a[i][AddrW-1:0];
               rsp_tdata[NumOct*AddrW + i] <= 1'b1;
            end else begin
               rsp_tdata[i*AddrW +: AddrW] <= '0;
               rsp_tdata[NumOct*AddrW + i] <= 1'b0;
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== tb/cop_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cop_checker
// Watches the column, register and address channels of the circle octant
// addresser, predicts each column's octant addresses and compares them.
// ----------------------------------------------------------------------------
module cop_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_data,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [15:0]  req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [183:0] rsp_tdata,
   input  wire logic         rsp_tuser,
   output int                fail_count,
   output int                pending
);
   import cop_pkg::*;

   typedef struct packed {
      logic [183:0] addrs;
      logic         active;
   } column_addrs_type;

   localparam longint MAX_W_C = DefMaxW;
   localparam longint MAX_H_C = DefMaxH;

   logic [9:0]  cx_q, cy_q, rx_q, ry_q;
   logic [10:0] w_q, h_q;
   column_addrs_type expected_columns[$];

   function automatic longint root_floor(longint v);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function automatic column_addrs_type octant_addrs(logic [9:0] xo);
      column_addrs_type res;
      longint x, d, w, h, cx, cy, e, k, y, lim, a;
      longint rows[8], cols[8];
      res = '0;
      x = xo; cx = cx_q; cy = cy_q;
      d = (cx - longint'(rx_q)) ** 2 + (cy - longint'(ry_q)) ** 2;
      w = (w_q > MAX_W_C) ? MAX_W_C : w_q;
      h = (h_q > MAX_H_C) ? MAX_H_C : h_q;
      res.active = ((2 * x + 1) * (2 * x + 1) <= 2 * d);
      if (res.active) begin
         e = d - x * x;
         k = root_floor(e);
         y = k + ((e > k * k + k) ? 1 : 0);
         if (!(x > w || y > h)) begin
            rows = '{cy + y, cy + x, cy + x, cy - y, cy - y, cy - x, cy - x, cy + y};
            cols = '{cx + x, cx + y, cx - y, cx + x, cx - x, cx - y, cx + y, cx - x};
            lim = 4 * w * h;
            for (int i = 0; i < 8; i++) begin
               a = 4 * w * rows[i] + 4 * cols[i];
               if (a >= 0 && a < lim) begin
                  res.addrs[i*22 +: 22] = a[21:0];
                  res.addrs[176 + i] = 1'b1;
               end
            end
         end
      end
      return res;
   endfunction

   assign pending = expected_columns.size();

   always @(posedge clock) begin
      column_addrs_type exp_c;
      int errs;
      errs = 0;
      if (reset) begin
         cx_q <= '0; cy_q <= '0; rx_q <= '0; ry_q <= '0;
         w_q <= 11'd1024; h_q <= 11'd1024;
         fail_count <= 0;
         expected_columns.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_columns.push_back(octant_addrs(req_tdata[9:0]));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CENTER_X: cx_q <= csr_data[9:0];
               REG_CENTER_Y: cy_q <= csr_data[9:0];
               REG_RIM_X:    rx_q <= csr_data[9:0];
               REG_RIM_Y:    ry_q <= csr_data[9:0];
               REG_WIDTH:    w_q  <= csr_data[10:0];
               REG_HEIGHT:   h_q  <= csr_data[10:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_columns.size() == 0) begin
               $error("unexpected beat: tdata %h", rsp_tdata);
               errs++;
            end else begin
               exp_c = expected_columns.pop_front();
               for (int i = 0; i < 8; i++)
                  if (rsp_tdata[i*22 +: 22] !== exp_c.addrs[i*22 +: 22]) begin
                     $error("addr_oct%0d: expected %h actual %h", i,
                            exp_c.addrs[i*22 +: 22], rsp_tdata[i*22 +: 22]);
                     errs++;
                  end
               if (rsp_tdata[183:176] !== exp_c.addrs[183:176]) begin
                  $error("valid_mask: expected %h actual %h",
                         exp_c.addrs[183:176], rsp_tdata[183:176]);
                  errs++;
               end
               if (rsp_tuser !== exp_c.active) begin
                  $error("column_active: expected %b actual %b",
                         exp_c.active, rsp_tuser);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives circle settings and column offsets into the octant addresser with
// random gaps and stalls, including a long output hold-off; the checker
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
   import cop_pkg::*;

   // register indexes with no register behind them
   localparam logic [CsrIdxW-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CsrIdxW-1:0] REG_SPARE_HI = 3'd7;

   logic         clock, reset;
   logic         csr_valid, csr_ready;
   logic [2:0]   csr_index;
   logic [15:0]  csr_data;
   logic         req_tvalid, req_tready;
   logic [15:0]  req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [183:0] rsp_tdata;
   logic         rsp_tuser;
   int           fail_count, pending;
   int           idle_cycles;
   bit           quiet_phase, hold_phase;

   circle_octant_pixel_addresser_top DUT (.*);

   cop_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver: random stall bursts, one long hold-off
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_phase) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_phase = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 10);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_column(input logic [9:0] x);
      int n;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'(0), x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_pipe;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_circle(input int cx, cy, rx, ry, w, h);
      write_reg(REG_CENTER_X, 16'(cx));
      write_reg(REG_CENTER_Y, 16'(cy));
      write_reg(REG_RIM_X, 16'(rx));
      write_reg(REG_RIM_Y, 16'(ry));
      write_reg(REG_WIDTH, 16'(w));
      write_reg(REG_HEIGHT, 16'(h));
   endtask

   // columns mostly inside the active span, some beyond it
   task automatic random_columns(input int count);
      int span;
      for (int i = 0; i < count; i++) begin
         span = $urandom_range(0, 9) == 0 ? 1023 : 760;
         send_column(10'($urandom_range(0, span)));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      req_tvalid = 1'b0; req_tdata = '0;
      quiet_phase = 1'b0; hold_phase = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: zero radius, then directed extremes
      send_column(10'd0);
      send_column(10'd1023);
      drain_pipe();
      set_circle(512, 512, 512, 0, 1024, 1024);
      for (int x = 0; x < 6; x++) send_column(10'(x));
      send_column(10'd361);
      send_column(10'd362);
      send_column(10'd1023);
      drain_pipe();
      // corner center: wrapping and invalid octants
      set_circle(1023, 1023, 0, 0, 2047, 2047);
      send_column(10'd0);
      send_column(10'd723);
      send_column(10'd1023);
      drain_pipe();
      // tiny image: skipped columns, zero size, unknown register
      set_circle(3, 3, 8, 3, 1, 1);
      for (int x = 0; x < 4; x++) send_column(10'(x));
      drain_pipe();
      write_reg(REG_WIDTH, 16'd0);
      write_reg(REG_SPARE_LO, 16'hffff);
      write_reg(REG_SPARE_HI, 16'h0);
      send_column(10'd1);
      send_column(10'd2);
      drain_pipe();

      // long hold-off while columns keep coming
      set_circle(400, 300, 100, 50, 640, 480);
      hold_phase = 1'b1;
      random_columns(80);
      drain_pipe();

      for (int ph = 0; ph < 8; ph++) begin
         set_circle($urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 5) == 0 ? 2047 : $urandom_range(1, 1024),
                    $urandom_range(0, 5) == 0 ? 2047 : $urandom_range(1, 1024));
         if (ph == 7) quiet_phase = 1'b1;
         random_columns(105);
         drain_pipe();
      end

      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/cop_pkg.sv
rtl/circle_octant_pixel_addresser_top.sv
tb/cop_checker.sv
tb/tb.sv
